### rtl/assert_macros.svh
// Assertion macros shared by the checker files of the project.
// Each macro wraps one clocked concurrent property with an active-low reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds at the same edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### rtl/lsv_pkg.sv
// Package for the largest substring variance block: types, score constants and
// the controller states. Depends on nothing.
`timescale 1ns / 1ps

package lsv_pkg;

    localparam int LETTER_W = 5;
    localparam int SCORE_W  = 16;
    localparam int OUT_W    = 14;
    localparam int MAX_LEN  = 16384;
    localparam int OUT_MAX  = 16383;

    // Scores saturate upward at the smaller of MAX_LEN-1 and the output range.
    localparam logic signed [SCORE_W-1:0] SCORE_CAP =
        SCORE_W'((MAX_LEN - 1) < OUT_MAX ? (MAX_LEN - 1) : OUT_MAX);

    // Stand-in for minus infinity; reachable scores never drop below -1.
    localparam logic signed [SCORE_W-1:0] NEG_INF = {1'b1, {(SCORE_W-1){1'b0}}};

    // One memory word per ordered letter pair. The ended score without an a
    // never reaches the result, so it is not kept.
    typedef struct packed {
        logic signed [SCORE_W-1:0] in0;
        logic signed [SCORE_W-1:0] in1;
        logic signed [SCORE_W-1:0] end1;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;      // latch the accepted word and rewind the sweep
        logic step;      // read the current pair entry and advance
        logic finish;    // item done, update the string-start flag
        logic load_out;  // copy the running maximum into the output register
    } t_cmd;

    typedef struct packed {
        logic sweep_end; // current pair entry is the final one
        logic last_q;    // the item in work closes its string
    } t_sts;

endpackage

### rtl/lsv_ctrl.sv
// Sequencer for the largest substring variance block: state machine, input
// stall and output valid. Depends on lsv_pkg.
`timescale 1ns / 1ps

module lsv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  lsv_pkg::t_sts i_sts,
    output lsv_pkg::t_cmd o_cmd
);

    lsv_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsv_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            lsv_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lsv_pkg::S_SWEEP;
                end
            end
            lsv_pkg::S_SWEEP: begin
                o_cmd.step = 1'b1;
                if (i_sts.sweep_end) begin
                    n_state = lsv_pkg::S_DRAIN;
                end
            end
            lsv_pkg::S_DRAIN: begin
                o_cmd.finish = 1'b1;
                n_state      = i_sts.last_q ? lsv_pkg::S_OUT : lsv_pkg::S_IDLE;
            end
            lsv_pkg::S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = lsv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lsv_pkg::S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != lsv_pkg::S_IDLE);
    assign o_valid = r_out_valid;

endmodule

### rtl/lsv_dp.sv
// Datapath for the largest substring variance block: pair score memory, sweep
// counters, score update and running maximum. Depends on lsv_pkg.
`timescale 1ns / 1ps

module lsv_dp #(
    parameter int ALPHABET = 26
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [lsv_pkg::LETTER_W-1:0] i_letter,
    input  logic                         i_last,
    input  lsv_pkg::t_cmd                i_cmd,
    output lsv_pkg::t_sts                o_sts,
    output logic [lsv_pkg::OUT_W-1:0]    o_variance
);

    localparam int NPAIR = ALPHABET * (ALPHABET - 1);
    localparam int AW    = (NPAIR > 1) ? $clog2(NPAIR) : 1;
    localparam int LW    = $clog2(ALPHABET);
    localparam int JW    = (ALPHABET > 2) ? $clog2(ALPHABET - 1) : 1;

    lsv_pkg::t_entry r_mem [NPAIR];

    logic [lsv_pkg::LETTER_W-1:0]       r_letter;
    logic                               r_last;
    logic                               r_fresh;
    logic [LW-1:0]                      r_a;
    logic [JW-1:0]                      r_j;
    logic [AW-1:0]                      r_addr;
    logic                               r_wr_valid;
    logic [AW-1:0]                      r_wr_addr;
    logic                               r_is_a;
    logic                               r_is_b;
    lsv_pkg::t_entry                    r_rd;
    logic signed [lsv_pkg::SCORE_W-1:0] r_best;
    logic [lsv_pkg::OUT_W-1:0]          r_variance;

    logic [LW-1:0]                      j_ext;
    logic [LW-1:0]                      b_cur;
    logic                               is_a;
    logic                               is_b;
    lsv_pkg::t_entry                    cur;
    lsv_pkg::t_entry                    upd;
    logic signed [lsv_pkg::SCORE_W-1:0] m01;
    logic signed [lsv_pkg::SCORE_W-1:0] base0;
    logic signed [lsv_pkg::SCORE_W-1:0] sum0;
    logic signed [lsv_pkg::SCORE_W-1:0] sum1;
    logic signed [lsv_pkg::SCORE_W-1:0] wgt;
    logic signed [lsv_pkg::SCORE_W-1:0] best_a;
    logic signed [lsv_pkg::SCORE_W-1:0] best_b;

    // Pair (a, b) skips the diagonal: b is j below a and j+1 from a upward.
    assign j_ext = LW'(r_j);
    assign b_cur = (j_ext < r_a) ? j_ext : j_ext + LW'(1);
    assign is_a  = (r_letter == lsv_pkg::LETTER_W'(r_a));
    assign is_b  = (r_letter == lsv_pkg::LETTER_W'(b_cur));

    assign o_sts.sweep_end = (r_addr == AW'(NPAIR - 1));
    assign o_sts.last_q    = r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_rd <= r_mem[r_addr];
        end
        if (r_wr_valid) begin
            r_mem[r_wr_addr] <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh    <= 1'b1;
            r_wr_valid <= 1'b0;
        end else begin
            r_wr_valid <= i_cmd.step;
            if (i_cmd.finish) begin
                r_fresh <= r_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_letter <= i_letter;
            r_last   <= i_last;
            r_a      <= '0;
            r_j      <= '0;
            r_addr   <= '0;
        end else if (i_cmd.step) begin
            r_addr <= r_addr + AW'(1);
            if (r_j == JW'(ALPHABET - 2)) begin
                r_j <= '0;
                r_a <= r_a + LW'(1);
            end else begin
                r_j <= r_j + JW'(1);
            end
        end
        if (i_cmd.step) begin
            r_wr_addr <= r_addr;
            r_is_a    <= is_a;
            r_is_b    <= is_b;
        end
        if (i_cmd.load) begin
            r_best <= '0;
        end else if (r_wr_valid) begin
            r_best <= best_b;
        end
        if (i_cmd.load_out) begin
            r_variance <= r_best[lsv_pkg::OUT_W-1:0];
        end
    end

    // At the start of a string every stored entry reads as minus infinity.
    always_comb begin
        if (r_fresh) begin
            cur.in0  = lsv_pkg::NEG_INF;
            cur.in1  = lsv_pkg::NEG_INF;
            cur.end1 = lsv_pkg::NEG_INF;
        end else begin
            cur = r_rd;
        end
    end

    always_comb begin
        wgt   = r_is_b ? lsv_pkg::SCORE_W'(1) : '0;
        m01   = (cur.in0 > cur.in1) ? cur.in0 : cur.in1;
        if (m01 < 0) begin
            m01 = '0;
        end
        base0 = (cur.in0 > 0) ? cur.in0 : '0;
        sum0  = base0 + wgt;
        sum1  = cur.in1 + wgt;
        upd.end1 = (cur.in1 > cur.end1) ? cur.in1 : cur.end1;
        if (r_is_a) begin
            upd.in0 = lsv_pkg::NEG_INF;
            upd.in1 = m01 - lsv_pkg::SCORE_W'(1);
        end else begin
            upd.in0 = (sum0 > lsv_pkg::SCORE_CAP) ? lsv_pkg::SCORE_CAP : sum0;
            if (cur.in1 == lsv_pkg::NEG_INF) begin
                upd.in1 = lsv_pkg::NEG_INF;
            end else begin
                upd.in1 = (sum1 > lsv_pkg::SCORE_CAP) ? lsv_pkg::SCORE_CAP : sum1;
            end
        end
        best_a = (upd.in1 > r_best) ? upd.in1 : r_best;
        best_b = (upd.end1 > best_a) ? upd.end1 : best_a;
    end

    assign o_variance = r_variance;

endmodule

### rtl/largest_substring_variance.sv
// Largest substring variance over a stream of letter codes; top level joining
// lsv_ctrl and lsv_dp, types from lsv_pkg.
// Each word makes one read-modify-write of every letter-pair entry through the
// single pair memory. A word marked last then passes the output state, which
// loads the output register once that register is free or being read.
// Reset is synchronous and needs no clearing pass; the first sweep ignores memory.
`timescale 1ns / 1ps

module largest_substring_variance #(
    parameter int ALPHABET = 26
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [lsv_pkg::LETTER_W-1:0] i_letter,
    input  logic                         i_last,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [lsv_pkg::OUT_W-1:0]    o_variance
);

    // The controller sequences one word at a time: it accepts a word while idle,
    // then steps the datapath through every ordered pair (a, b) with a != b.
    // The result sits in its own output register, so a new word is accepted
    // even while a finished result waits on a stalled receiver.
    lsv_pkg::t_cmd cmd;
    lsv_pkg::t_sts sts;

    lsv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The datapath holds one memory word per pair with the in-progress scores
    // split on whether letter a has been seen, and the ended score with an a. A
    // string-start flag makes every entry read as minus infinity during the
    // first sweep of a string, which stands in for clearing the memory both
    // after reset and after a word marked last.
    lsv_dp #(
        .ALPHABET (ALPHABET)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_letter   (i_letter),
        .i_last     (i_last),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_variance (o_variance)
    );

endmodule

### rtl/lsv_checker.sv
// Port-level checker for largest_substring_variance, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [13:0] o_variance
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_variance))
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `ASSERT_IMPL(a_result_after_work, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))

endmodule

bind largest_substring_variance lsv_checker u_lsv_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_variance (o_variance)
);

### verif/tb_top.sv
// Self-checking bench for largest_substring_variance: random and directed letter strings,
// a built-in scoring model of every letter pair, and handshake idling on both sides.
// Depends on lsv_pkg and the largest_substring_variance RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int ALPHA = 26;
    // A score that no substring can reach yet.
    localparam int NO_SCORE = -1000000;
    localparam int SCORE_LIMIT = (lsv_pkg::MAX_LEN - 1 < lsv_pkg::OUT_MAX) ?
                                 lsv_pkg::MAX_LEN - 1 : lsv_pkg::OUT_MAX;
    // The receiver's long hold-off, started once when this many results have come.
    localparam int HOLD_CYCLES = 5000;
    localparam int HOLD_AT = 20;
    // The hold-off dominates the longest quiet stretch.
    localparam int QUIET_LIMIT = 20000;
    localparam int TAIL_CYCLES = 700;

    typedef struct packed {
        logic [lsv_pkg::LETTER_W-1:0] letter;
        logic                         last;
    } t_char;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [lsv_pkg::LETTER_W-1:0] i_letter = '0;
    logic                         i_last = 1'b0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic [lsv_pkg::OUT_W-1:0]    o_variance;

    // Words waiting to be offered, and variances waiting to come out.
    t_char                     char_queue[$];
    logic [lsv_pkg::OUT_W-1:0] variance_due[$];
    t_char                     head_char;
    logic [lsv_pkg::OUT_W-1:0] want_variance;

    // Per ordered pair (x, y): best running score with no x yet, with an x, and the
    // best ended score that holds an x. Only the last two can reach the result.
    int run_no_x[ALPHA][ALPHA];
    int run_with_x[ALPHA][ALPHA];
    int done_with_x[ALPHA][ALPHA];

    int gap_pct = 19;
    int stall_pct = 84;
    int queued = 0;
    int results_seen = 0;
    int hold_left = 0;
    int quiet_run = 0;
    int mismatches = 0;

    largest_substring_variance #(.ALPHABET(ALPHA)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_letter   (i_letter),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_variance (o_variance)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int bigger(int p, int q);
        return (p > q) ? p : q;
    endfunction

    function automatic int capped(int v);
        return (v > SCORE_LIMIT) ? SCORE_LIMIT : v;
    endfunction

    task automatic clear_pairs();
        for (int x = 0; x < ALPHA; x++) begin
            for (int y = 0; y < ALPHA; y++) begin
                run_no_x[x][y] = NO_SCORE;
                run_with_x[x][y] = NO_SCORE;
                done_with_x[x][y] = NO_SCORE;
            end
        end
    endtask

    // Advances every pair by one letter. The letter counts -1 for the first letter
    // of the pair, +1 for the second, 0 otherwise, and codes past the alphabet
    // count for nobody. On a closing letter the best pair score, floored at zero,
    // becomes the expected variance and all pairs start over.
    task automatic score_letter(input logic [lsv_pkg::LETTER_W-1:0] letter, input logic last);
        int w;
        int open0;
        int open1;
        int best;
        best = 0;
        for (int x = 0; x < ALPHA; x++) begin
            for (int y = 0; y < ALPHA; y++) begin
                if (x != y) begin
                    w = (letter == x) ? -1 : ((letter == y) ? 1 : 0);
                    open0 = run_no_x[x][y];
                    open1 = run_with_x[x][y];
                    done_with_x[x][y] = bigger(open1, done_with_x[x][y]);
                    if (w < 0) begin
                        run_no_x[x][y] = NO_SCORE;
                        run_with_x[x][y] = bigger(0, bigger(open0, open1)) - 1;
                    end else begin
                        run_no_x[x][y] = capped(bigger(0, open0) + w);
                        run_with_x[x][y] = (open1 == NO_SCORE) ? NO_SCORE : capped(open1 + w);
                    end
                    best = bigger(best, bigger(run_with_x[x][y], done_with_x[x][y]));
                end
            end
        end
        if (last) begin
            variance_due.push_back(best[lsv_pkg::OUT_W-1:0]);
            clear_pairs();
        end
    endtask

    task automatic push_char(input logic [lsv_pkg::LETTER_W-1:0] letter, input logic last);
        t_char c;
        c.letter = letter;
        c.last = last;
        char_queue.push_back(c);
        queued++;
    endtask

    // Driver: offers the next queued word, holds it while stalled, and feeds
    // every accepted word to the pair model.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            clear_pairs();
        end else begin
            if (i_valid && !o_stall) begin
                score_letter(i_letter, i_last);
            end
            if (!i_valid || !o_stall) begin
                if (char_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    head_char = char_queue.pop_front();
                    i_valid <= 1'b1;
                    i_letter <= head_char.letter;
                    i_last <= head_char.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest expected variance
    // and drives the stall, including one long hold-off that lets the block back up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (variance_due.size() == 0) begin
                    $error("unexpected variance word, actual %0d", o_variance);
                    mismatches++;
                end else begin
                    want_variance = variance_due.pop_front();
                    if (o_variance !== want_variance) begin
                        $error("variance: expected %0d, actual %0d", want_variance, o_variance);
                        mismatches++;
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_stall <= 1'b1;
            end else if (o_valid && !i_stall && results_seen == HOLD_AT - 1) begin
                hold_left <= HOLD_CYCLES;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Watchdog: a long run of cycles with no word moving on either side is a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_run <= 0;
            end else if (quiet_run >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_run <= quiet_run + 1;
            end
        end
    end

    initial begin : stimulus
        int phase_goal[3];
        int len;
        int flavor;
        logic [lsv_pkg::LETTER_W-1:0] ch_lo;
        logic [lsv_pkg::LETTER_W-1:0] ch_mid;
        logic [lsv_pkg::LETTER_W-1:0] ch_hi;
        logic [lsv_pkg::LETTER_W-1:0] pick;
        phase_goal[0] = 300;
        phase_goal[1] = 600;
        phase_goal[2] = 920;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A single letter has no second letter to pair with.
        push_char(5'd0, 1'b1);
        // Two letters, the heavier one around a single light one.
        push_char(5'd1, 1'b0);
        push_char(5'd0, 1'b0);
        push_char(5'd1, 1'b0);
        push_char(5'd1, 1'b1);
        // Codes past the alphabet are characters that weigh nothing.
        push_char(5'd31, 1'b0);
        push_char(5'd26, 1'b0);
        push_char(5'd0, 1'b0);
        push_char(5'd25, 1'b0);
        push_char(5'd25, 1'b1);
        // One repeated letter reaches no pair.
        push_char(5'd3, 1'b0);
        push_char(5'd3, 1'b0);
        push_char(5'd3, 1'b1);
        // Only codes past the alphabet.
        push_char(5'd30, 1'b1);
        // The light letter comes after the heavy run.
        push_char(5'd25, 1'b0);
        push_char(5'd25, 1'b0);
        push_char(5'd25, 1'b0);
        push_char(5'd0, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                gap_pct = 84;
                stall_pct = 19;
            end else if (phase == 2) begin
                gap_pct = 0;
                stall_pct = 0;
            end
            // Mostly short strings; most lean on one letter against one or two
            // others so that variances grow, the rest are uniform or noisy.
            while (queued < phase_goal[phase]) begin
                len = ($urandom_range(4) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
                flavor = $urandom_range(9);
                ch_lo = lsv_pkg::LETTER_W'($urandom_range(25));
                ch_mid = lsv_pkg::LETTER_W'($urandom_range(25));
                ch_hi = lsv_pkg::LETTER_W'($urandom_range(25));
                for (int k = 0; k < len; k++) begin
                    if (flavor < 6) begin
                        pick = ($urandom_range(9) < 7) ? ch_hi
                             : ($urandom_range(1) ? ch_lo : ch_mid);
                    end else if (flavor < 9) begin
                        pick = lsv_pkg::LETTER_W'($urandom_range(25));
                    end else begin
                        pick = lsv_pkg::LETTER_W'($urandom_range(31));
                    end
                    push_char(pick, k == len - 1);
                end
            end
            wait (char_queue.size() == 0);
            @(negedge i_clk);
        end

        // Every word accepted, then every result in, then a quiet tail for strays.
        wait (char_queue.size() == 0 && !i_valid);
        wait (variance_due.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### largest_substring_variance.f
+incdir+rtl
rtl/lsv_pkg.sv
rtl/lsv_ctrl.sv
rtl/lsv_dp.sv
rtl/largest_substring_variance.sv
rtl/lsv_checker.sv
verif/tb_top.sv
